// ===== rtl/core/cvz_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvz_pkg
// Shared constants and types for the 3x3 zero-padded stream filter.
// ----------------------------------------------------------------------------
package cvz_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int COEF_FRAC_BITS = 8;
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int IMG_W_W        = 11;
    localparam int IMG_H_W        = 13;
    localparam int ROW_W          = 13;
    localparam int PIX_W          = 8;
    localparam int COEF_W         = 16;
    localparam int PROD_W         = PIX_W + 1 + COEF_W;
    localparam int SUM_W          = PROD_W + 4;

    localparam int CFG_DATA_W     = 64;
    localparam int CFG_ADDR_W     = 6;
    localparam int CFG_REG_W      = 3 * COEF_W;
    localparam int CFG_IDX_W      = CFG_ADDR_W - 3;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MID    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT  = 3'd4;

    localparam logic [CFG_REG_W-1:0] COEF_TOP_RST    = 48'h0000_0000_0000;
    localparam logic [CFG_REG_W-1:0] COEF_MID_RST    = 48'h0000_0100_0000;
    localparam logic [CFG_REG_W-1:0] COEF_BOTTOM_RST = 48'h0000_0000_0000;
    localparam logic [IMG_W_W-1:0]   IMG_W_RST       = 11'd640;
    localparam logic [IMG_H_W-1:0]   IMG_H_RST       = 13'd480;

    // items in flight between acceptance and the output queue
    localparam int PIPE_ITEMS     = 4;
    localparam int OQ_DEPTH       = 16;
    localparam int OQ_PTR_W       = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W       = OQ_PTR_W + 1;
    localparam int OQ_STALL_LEVEL = OQ_DEPTH - 2 * (PIPE_ITEMS + 1);

    typedef logic [PIX_W-1:0]               t_pix;
    typedef logic [2:0][2:0][PIX_W-1:0]     t_win;
    typedef logic [2:0][CFG_REG_W-1:0]      t_coef_set;

    typedef struct packed {
        logic has0;
        logic has1;
        logic frame_end;
    } t_tag;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             eol;
        logic             eof;
        logic             last;
    } t_result;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        t_pix             px;
        logic             ge1;
        logic             ge2;
        logic             zero_col;
        t_tag             tag;
    } t_s1;

endpackage
`default_nettype wire

// ===== rtl/core/conv3x3_zero_pad_stream_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_stream_unit
// 3x3 zero-padded filter over a raster pixel stream, signed Q8.8 weights.
// Accepts one item per clock unless o_in_stall is high; past the first row a
// row-end item yields two results (one in a one-pixel-wide row). Results
// pass the line-store read at acceptance, the window register, the two
// multiply/sum stages and the result queue write on their way out.
// Reset clears counters, pipeline valids and the result queue and loads
// the register defaults; line stores are not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module conv3x3_zero_pad_stream_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_kind,
    input  wire logic [cvz_pkg::PIX_W-1:0]      i_pixel,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [cvz_pkg::PIX_W-1:0]           o_out_pixel,
    output logic                                o_end_of_line,
    output logic                                o_end_of_frame,
    output logic                                o_last,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cvz_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [cvz_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [cvz_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready
);
    import cvz_pkg::*;

    // configuration
    logic [CFG_REG_W-1:0] r_coef_top;
    logic [CFG_REG_W-1:0] r_coef_mid;
    logic [CFG_REG_W-1:0] r_coef_bot;
    logic [IMG_W_W-1:0]   r_img_w;
    logic [IMG_H_W-1:0]   r_img_h;
    logic [CFG_IDX_W-1:0] w_cfg_idx;
    logic                 w_cfg_wr;

    // stage 0
    logic                 w_accept;
    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;
    logic [IMG_W_W-1:0]   w_weff;
    logic [IMG_H_W-1:0]   w_heff;
    logic [COL_W-1:0]     w_c0;
    logic [ROW_W-1:0]     w_r0;
    logic                 w_row_end;
    logic                 w_col_wrap;
    t_s1                  n_s1;
    logic [COL_W-1:0]     n_col;
    logic [ROW_W-1:0]     n_row;

    // stage 1
    t_s1                  r_s1;
    logic                 r_byp;
    t_pix                 r_byp_prev;
    t_pix                 r_byp_prev2;
    t_pix                 w_rd_prev;
    t_pix                 w_rd_prev2;
    t_pix                 w_prev_raw;
    t_pix                 w_prev2_raw;
    t_win                 r_win;
    t_win                 n_win;

    // stage 2
    logic                 r_s2_valid;
    t_tag                 r_s2_tag;

    logic                 w_push0;
    logic                 w_push1;
    t_result              w_res0;
    t_result              w_res1;
    t_result              w_head;
    logic                 w_q_high;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[CFG_ADDR_W-1:3];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_top <= COEF_TOP_RST;
            r_coef_mid <= COEF_MID_RST;
            r_coef_bot <= COEF_BOTTOM_RST;
            r_img_w    <= IMG_W_RST;
            r_img_h    <= IMG_H_RST;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_COEF_TOP:    r_coef_top <= pwdata[CFG_REG_W-1:0];
                REG_COEF_MID:    r_coef_mid <= pwdata[CFG_REG_W-1:0];
                REG_COEF_BOTTOM: r_coef_bot <= pwdata[CFG_REG_W-1:0];
                REG_IMG_WIDTH:   r_img_w    <= pwdata[IMG_W_W-1:0];
                REG_IMG_HEIGHT:  r_img_h    <= pwdata[IMG_H_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_COEF_TOP:    prdata = CFG_DATA_W'(r_coef_top);
            REG_COEF_MID:    prdata = CFG_DATA_W'(r_coef_mid);
            REG_COEF_BOTTOM: prdata = CFG_DATA_W'(r_coef_bot);
            REG_IMG_WIDTH:   prdata = CFG_DATA_W'(r_img_w);
            REG_IMG_HEIGHT:  prdata = CFG_DATA_W'(r_img_h);
            default:         prdata = '0;
        endcase
    end

    // ---------------- stage 0: position, line-store read ----------------
    assign w_accept = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_img_w == '0) begin
            w_weff = IMG_W_W'(1);
        end else if (r_img_w > IMG_W_W'(MAX_WIDTH)) begin
            w_weff = IMG_W_W'(MAX_WIDTH);
        end else begin
            w_weff = r_img_w;
        end
        w_heff = (r_img_h == '0) ? IMG_H_W'(1) : r_img_h;
        w_c0   = (IMG_W_W'(r_col) >= w_weff) ? '0 : r_col;
        w_r0   = (r_row > ROW_W'(w_heff)) ? '0 : r_row;
    end

    assign w_row_end  = (IMG_W_W'(w_c0) == w_weff - IMG_W_W'(1));
    assign w_col_wrap = (IMG_W_W'(w_c0) + IMG_W_W'(1) >= w_weff);

    always_comb begin
        n_s1.valid        = 1'b1;
        n_s1.col          = w_c0;
        n_s1.px           = (i_kind || (w_r0 >= ROW_W'(w_heff))) ? '0 : i_pixel;
        n_s1.ge1          = (w_r0 != '0);
        n_s1.ge2          = (w_r0 >= ROW_W'(2));
        n_s1.zero_col     = (w_c0 == '0);
        n_s1.tag.has0     = n_s1.ge1 && !n_s1.zero_col;
        n_s1.tag.has1     = n_s1.ge1 && w_row_end;
        n_s1.tag.frame_end = (w_r0 == ROW_W'(w_heff));
        if (w_col_wrap) begin
            n_col = '0;
            n_row = (w_r0 >= ROW_W'(w_heff)) ? '0 : w_r0 + ROW_W'(1);
        end else begin
            n_col = w_c0 + COL_W'(1);
            n_row = w_r0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1.valid <= 1'b0;
            r_byp      <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
                r_s1  <= n_s1;
            end else begin
                r_s1.valid <= 1'b0;
            end
            r_byp      <= w_accept && r_s1.valid && (r_s1.col == w_c0);
            r_s2_valid <= r_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        // write to the column being read in the same cycle
        r_byp_prev  <= r_s1.px;
        r_byp_prev2 <= w_prev_raw;
    end

    cvz_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_prev (
        .i_clk   (i_clk),
        .i_we    (r_s1.valid),
        .i_waddr (r_s1.col),
        .i_wdata (r_s1.px),
        .i_re    (w_accept),
        .i_raddr (w_c0),
        .o_rdata (w_rd_prev)
    );

    cvz_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_prev2 (
        .i_clk   (i_clk),
        .i_we    (r_s1.valid),
        .i_waddr (r_s1.col),
        .i_wdata (w_prev_raw),
        .i_re    (w_accept),
        .i_raddr (w_c0),
        .o_rdata (w_rd_prev2)
    );

    // ---------------- stage 1: window update ----------------
    assign w_prev_raw  = r_byp ? r_byp_prev  : w_rd_prev;
    assign w_prev2_raw = r_byp ? r_byp_prev2 : w_rd_prev2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_s1.zero_col ? '0 : r_win[i][1];
            n_win[i][1] = r_s1.zero_col ? '0 : r_win[i][2];
        end
        n_win[0][2] = r_s1.ge2 ? w_prev2_raw : '0;
        n_win[1][2] = r_s1.ge1 ? w_prev_raw  : '0;
        n_win[2][2] = r_s1.px;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1.valid) begin
            r_win <= n_win;
        end
        r_s2_tag <= r_s1.tag;
    end

    // ---------------- stage 2+: filter and result queue ----------------
    cvz_kernel u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid),
        .i_tag   (r_s2_tag),
        .i_win   (r_win),
        .i_coef  ({r_coef_bot, r_coef_mid, r_coef_top}),
        .o_push0 (w_push0),
        .o_push1 (w_push1),
        .o_res0  (w_res0),
        .o_res1  (w_res1)
    );

    cvz_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (w_push0),
        .i_push1 (w_push1),
        .i_res0  (w_res0),
        .i_res1  (w_res1),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_head  (w_head),
        .o_high  (w_q_high)
    );

    assign o_in_stall     = w_q_high;
    assign o_out_pixel    = w_head.pix;
    assign o_end_of_line  = w_head.eol;
    assign o_end_of_frame = w_head.eof;
    assign o_last         = w_head.last;

    // ---------------- assertions ----------------
    a_accept_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s1.valid && (r_s1.col == $past(w_c0)))
        else $error("accepted item did not reach stage 1 at its column");

    a_bypass_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1.valid && r_byp |-> (r_s1.col == $past(r_s1.col)))
        else $error("line-store bypass taken for a different column");

    a_eof_is_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_frame |-> o_end_of_line && o_last)
        else $error("frame end flagged on a result that does not end its row");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_s1.valid)
        else $error("pipeline or queue not empty after reset");

endmodule
`default_nettype wire

// ===== rtl/core/cvz_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvz_ram
// Generic single-write, single-read RAM with registered read (old data on
// a same-address collision).
// ----------------------------------------------------------------------------
module cvz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/core/cvz_kernel.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvz_kernel
// 3x3 multiply-accumulate with round-half-even and 0..255 saturation.
// Products, then sums, are registered; rounding feeds the output queue.
// ----------------------------------------------------------------------------
module cvz_kernel (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire cvz_pkg::t_tag      i_tag,
    input  wire cvz_pkg::t_win      i_win,
    input  wire cvz_pkg::t_coef_set i_coef,
    output logic                    o_push0,
    output logic                    o_push1,
    output cvz_pkg::t_result        o_res0,
    output cvz_pkg::t_result        o_res1
);
    import cvz_pkg::*;

    localparam int Q_W = SUM_W - COEF_FRAC_BITS + 1;
    localparam logic [COEF_FRAC_BITS-1:0] HALF =
        COEF_FRAC_BITS'(1) << (COEF_FRAC_BITS - 1);

    function automatic logic [PIX_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [Q_W-1:0]      q;
        logic [COEF_FRAC_BITS-1:0]  rem;
        logic                       up;
        logic [PIX_W-1:0]           res;
        q   = Q_W'(s >>> COEF_FRAC_BITS);
        rem = s[COEF_FRAC_BITS-1:0];
        up  = (rem > HALF) || ((rem == HALF) && q[0]);
        q   = q + Q_W'(up);
        if (q[Q_W-1]) begin
            res = '0;
        end else if (q > Q_W'(255)) begin
            res = '1;
        end else begin
            res = q[PIX_W-1:0];
        end
        return res;
    endfunction

    logic signed [PROD_W-1:0] n_pf [3][3];
    logic signed [PROD_W-1:0] n_ps [3][2];
    logic signed [PROD_W-1:0] r_pf [3][3];
    logic signed [PROD_W-1:0] r_ps [3][2];
    logic                     r_a_valid;
    t_tag                     r_a_tag;

    logic signed [SUM_W-1:0]  n_sum_f;
    logic signed [SUM_W-1:0]  n_sum_s;
    logic signed [SUM_W-1:0]  r_sum_f;
    logic signed [SUM_W-1:0]  r_sum_s;
    logic                     r_b_valid;
    t_tag                     r_b_tag;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_pf[i][j] = $signed({1'b0, i_win[i][j]})
                           * $signed(i_coef[i][COEF_W*j +: COEF_W]);
            end
            n_ps[i][0] = $signed({1'b0, i_win[i][1]}) * $signed(i_coef[i][0 +: COEF_W]);
            n_ps[i][1] = $signed({1'b0, i_win[i][2]}) * $signed(i_coef[i][COEF_W +: COEF_W]);
        end
    end

    always_comb begin
        n_sum_f = '0;
        n_sum_s = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_sum_f = n_sum_f + SUM_W'(r_pf[i][j]);
            end
            n_sum_s = n_sum_s + SUM_W'(r_ps[i][0]) + SUM_W'(r_ps[i][1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pf    <= n_pf;
        r_ps    <= n_ps;
        r_a_tag <= i_tag;
        r_sum_f <= n_sum_f;
        r_sum_s <= n_sum_s;
        r_b_tag <= r_a_tag;
    end

    assign o_push0 = r_b_valid && r_b_tag.has0;
    assign o_push1 = r_b_valid && r_b_tag.has1;
    assign o_res0  = '{pix: round_sat(r_sum_f), eol: 1'b0, eof: 1'b0,
                       last: !r_b_tag.has1};
    assign o_res1  = '{pix: round_sat(r_sum_s), eol: 1'b1,
                       eof: r_b_tag.frame_end, last: 1'b1};

endmodule
`default_nettype wire

// ===== rtl/core/cvz_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cvz_outq
// Result queue: up to two writes per cycle, one read. Raises o_high early
// enough that every item already in the pipeline still finds room.
// ----------------------------------------------------------------------------
module cvz_outq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push0,
    input  wire logic             i_push1,
    input  wire cvz_pkg::t_result i_res0,
    input  wire cvz_pkg::t_result i_res1,
    input  wire logic             i_stall,
    output logic                  o_valid,
    output cvz_pkg::t_result      o_head,
    output logic                  o_high
);
    import cvz_pkg::*;

    t_result               r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   r_wp;
    logic [OQ_PTR_W-1:0]   r_rp;
    logic [OQ_CNT_W-1:0]   r_count;
    logic [OQ_PTR_W-1:0]   w_wp1;
    logic [OQ_CNT_W-1:0]   n_count;
    logic                  w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && !i_stall;
    assign w_wp1   = r_wp + OQ_PTR_W'(i_push0);
    assign n_count = r_count + OQ_CNT_W'(i_push0) + OQ_CNT_W'(i_push1)
                   - OQ_CNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wp] <= i_res0;
        end
        if (i_push1) begin
            r_mem[w_wp1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= w_wp1 + OQ_PTR_W'(i_push1);
            r_rp    <= r_rp + OQ_PTR_W'(w_pop);
            r_count <= n_count;
        end
    end

    assign o_head = r_mem[r_rp];
    assign o_high = (r_count > OQ_CNT_W'(OQ_STALL_LEVEL));

endmodule
`default_nettype wire

// ===== sim/conv3x3_zero_pad_stream_unit_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_stream_unit_check
// Watches the pixel, result and register channels of the 3x3 stream filter.
// Keeps its own copy of the registers, line stores and window, works out the
// filtered pixels each accepted item should produce, and compares every
// accepted result against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module conv3x3_zero_pad_stream_unit_check (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic                           i_flush,
    input  wire logic [cvz_pkg::PIX_W-1:0]      i_pixel,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic [cvz_pkg::PIX_W-1:0]      i_out_pixel,
    input  wire logic                           i_end_of_line,
    input  wire logic                           i_end_of_frame,
    input  wire logic                           i_last,
    input  wire logic                           i_psel,
    input  wire logic                           i_penable,
    input  wire logic                           i_pwrite,
    input  wire logic                           i_pready,
    input  wire logic [cvz_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  wire logic [cvz_pkg::CFG_DATA_W-1:0] i_pwdata,
    output int                                  o_errors,
    output int                                  o_waiting,
    output int                                  o_checked
);
    import cvz_pkg::*;

    typedef logic [2:0][2:0][PIX_W-1:0] t_nbhd;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             eol;
        logic             eof;
        logic             last;
    } t_filtered;

    logic [CFG_REG_W-1:0] kernel_rows [3];
    logic [IMG_W_W-1:0]   cfg_width;
    logic [IMG_H_W-1:0]   cfg_height;

    logic [PIX_W-1:0] row_above  [MAX_WIDTH];
    logic [PIX_W-1:0] row_above2 [MAX_WIDTH];
    t_nbhd            nbhd;
    int unsigned      col_pos;
    int unsigned      row_pos;

    t_filtered pending_pixels [$];
    int        errors;
    int        checked;

    assign o_errors  = errors;
    assign o_waiting = pending_pixels.size();
    assign o_checked = checked;

    // correlation sum, round half to even, clamp to 0..255
    function automatic logic [PIX_W-1:0] weigh_window(input t_nbhd nb);
        longint acc;
        longint q;
        longint rem;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc += longint'(nb[i][j]) *
                       longint'($signed(kernel_rows[i][COEF_W*j +: COEF_W]));
            end
        end
        q   = acc >>> COEF_FRAC_BITS;
        rem = acc & ((longint'(1) << COEF_FRAC_BITS) - 1);
        if (rem > (longint'(1) << (COEF_FRAC_BITS - 1)) ||
            (rem == (longint'(1) << (COEF_FRAC_BITS - 1)) && q[0])) begin
            q++;
        end
        if (q < 0) q = 0;
        if (q > 255) q = 255;
        return q[PIX_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] up1;
        logic [PIX_W-1:0] up2;
        logic             row_end;
        t_nbhd            shifted;
        t_filtered        want;
        t_filtered        got;

        if (!i_rst_n) begin
            kernel_rows[0] = COEF_TOP_RST;
            kernel_rows[1] = COEF_MID_RST;
            kernel_rows[2] = COEF_BOTTOM_RST;
            cfg_width      = IMG_W_RST;
            cfg_height     = IMG_H_RST;
            for (int k = 0; k < MAX_WIDTH; k++) begin
                row_above[k]  = '0;
                row_above2[k] = '0;
            end
            nbhd    = '0;
            col_pos = 0;
            row_pos = 0;
            errors  = 0;
            checked = 0;
            pending_pixels.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_out_pixel, i_end_of_line, i_end_of_frame, i_last};
                checked++;
                if (pending_pixels.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result pixel %0d eol %0b eof %0b last %0b",
                             $time, got.pix, got.eol, got.eof, got.last);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.pix !== want.pix) begin
                        errors++;
                        $display("%0t: out_pixel expected %0d actual %0d",
                                 $time, want.pix, got.pix);
                    end
                    if (got.eol !== want.eol) begin
                        errors++;
                        $display("%0t: end_of_line expected %0b actual %0b",
                                 $time, want.eol, got.eol);
                    end
                    if (got.eof !== want.eof) begin
                        errors++;
                        $display("%0t: end_of_frame expected %0b actual %0b",
                                 $time, want.eof, got.eof);
                    end
                    if (got.last !== want.last) begin
                        errors++;
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, got.last);
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                w = cfg_width;
                h = cfg_height;
                if (w == 0) w = 1;
                if (w > MAX_WIDTH) w = MAX_WIDTH;
                if (h == 0) h = 1;
                if (col_pos >= w) col_pos = 0;
                if (row_pos > h) row_pos = 0;
                c = col_pos;
                r = row_pos;

                px  = (i_flush || r >= h) ? '0 : i_pixel;
                up2 = (r >= 2) ? row_above2[c] : '0;
                up1 = (r >= 1) ? row_above[c] : '0;

                if (c == 0) nbhd = '0;
                for (int i = 0; i < 3; i++) begin
                    nbhd[i][0] = nbhd[i][1];
                    nbhd[i][1] = nbhd[i][2];
                end
                nbhd[0][2] = up2;
                nbhd[1][2] = up1;
                nbhd[2][2] = px;

                row_above2[c] = row_above[c];
                row_above[c]  = px;

                if (r >= 1) begin
                    row_end = (c == w - 1);
                    if (c >= 1) begin
                        want.pix  = weigh_window(nbhd);
                        want.eol  = 1'b0;
                        want.eof  = 1'b0;
                        want.last = !row_end;
                        pending_pixels.push_back(want);
                    end
                    if (row_end) begin
                        for (int i = 0; i < 3; i++) begin
                            shifted[i][0] = nbhd[i][1];
                            shifted[i][1] = nbhd[i][2];
                            shifted[i][2] = '0;
                        end
                        want.pix  = weigh_window(shifted);
                        want.eol  = 1'b1;
                        want.eof  = (r == h);
                        want.last = 1'b1;
                        pending_pixels.push_back(want);
                    end
                end

                if (c + 1 >= w) begin
                    col_pos = 0;
                    row_pos = (r >= h) ? 0 : r + 1;
                end else begin
                    col_pos = c + 1;
                end
            end

            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[CFG_ADDR_W-1:3])
                    REG_COEF_TOP:    kernel_rows[0] = i_pwdata[CFG_REG_W-1:0];
                    REG_COEF_MID:    kernel_rows[1] = i_pwdata[CFG_REG_W-1:0];
                    REG_COEF_BOTTOM: kernel_rows[2] = i_pwdata[CFG_REG_W-1:0];
                    REG_IMG_WIDTH:   cfg_width      = i_pwdata[IMG_W_W-1:0];
                    REG_IMG_HEIGHT:  cfg_height     = i_pwdata[IMG_H_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sim/conv3x3_zero_pad_stream_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_stream_unit_test
// Stimulus and verdict for the 3x3 stream filter. Directed frames hit the
// size corners, rounding ties and coefficient extremes; random frames follow
// with random kernels, stray flush ticks and stray pixels, a mid-frame resize,
// and one full-width row under a long output hold-off. Checking is in the
// checker.
// ----------------------------------------------------------------------------
module conv3x3_zero_pad_stream_unit_test;
    import cvz_pkg::*;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;
    localparam int   HOLD_CYCLES = 200;
    localparam int   SETTLE      = 16;
    localparam int   RAND_ITEMS  = 300;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_kind   = KIND_PIXEL;
    logic [PIX_W-1:0]      in_pixel  = '0;
    logic                  out_stall = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;

    logic                  in_stall;
    logic                  out_valid;
    logic [PIX_W-1:0]      out_pixel;
    logic                  end_of_line;
    logic                  end_of_frame;
    logic                  last;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int errors;
    int waiting;
    int checked;

    logic calm      = 1'b0;
    logic hold_req  = 1'b0;
    int   hold_left = 0;
    int   items_sent;
    int   frames;

    always #1 clk = ~clk;

    conv3x3_zero_pad_stream_unit uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_kind         (in_kind),
        .i_pixel        (in_pixel),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_pixel    (out_pixel),
        .o_end_of_line  (end_of_line),
        .o_end_of_frame (end_of_frame),
        .o_last         (last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    conv3x3_zero_pad_stream_unit_check checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_flush        (in_kind),
        .i_pixel        (in_pixel),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_pixel    (out_pixel),
        .i_end_of_line  (end_of_line),
        .i_end_of_frame (end_of_frame),
        .i_last         (last),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_errors       (errors),
        .o_waiting      (waiting),
        .o_checked      (checked)
    );

    // result side: random stalls, or a counted hold-off when requested
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left != 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 9);
            end
        end
    end

    task automatic send_item(input logic kind, input logic [PIX_W-1:0] pix);
        while (!calm && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= kind;
        in_pixel <= pix;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    // let every outstanding result drain, then give the pipeline time to empty
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_kernel(input logic [CFG_REG_W-1:0] top_row,
                               input logic [CFG_REG_W-1:0] mid_row,
                               input logic [CFG_REG_W-1:0] bot_row);
        quiesce();
        write_reg(REG_COEF_TOP, CFG_DATA_W'(top_row));
        write_reg(REG_COEF_MID, CFG_DATA_W'(mid_row));
        write_reg(REG_COEF_BOTTOM, CFG_DATA_W'(bot_row));
    endtask

    function automatic logic [CFG_REG_W-1:0] random_kernel_row();
        logic [CFG_REG_W-1:0] v;
        for (int k = 0; k < 3; k++) begin
            if ($urandom_range(3) == 0)
                v[COEF_W*k +: COEF_W] = COEF_W'($urandom_range(65535));
            else
                v[COEF_W*k +: COEF_W] = COEF_W'($urandom_range(768) - 384);
        end
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        int pick;
        pick = $urandom_range(15);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return PIX_W'($urandom_range(255));
    endfunction

    // full frame plus flush row at the given effective size; noise in percent
    task automatic run_frame(input int w, input int h, input int noise);
        for (int r = 0; r <= h; r++) begin
            for (int c = 0; c < w; c++) begin
                if (r < h)
                    send_item(($urandom_range(99) < noise) ? KIND_FLUSH : KIND_PIXEL,
                              random_pixel());
                else
                    send_item(($urandom_range(99) < noise) ? KIND_PIXEL : KIND_FLUSH,
                              random_pixel());
            end
        end
        frames++;
    endtask

    task automatic set_size(input int w, input int h);
        quiesce();
        write_reg(REG_IMG_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMG_HEIGHT, CFG_DATA_W'(h));
    endtask

    initial begin
        int w;
        int h;
        int rand_frames;

        items_sent = 0;
        frames     = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // width and height of zero act as one; reset kernel passes through
        set_size(0, 0);
        send_item(KIND_PIXEL, 8'd255);
        send_item(KIND_FLUSH, 8'd0);
        frames++;

        // center weight one half: both halves fall on ties, rounded to even
        load_kernel('0, 48'h0000_0080_0000, '0);
        send_item(KIND_PIXEL, 8'd5);
        send_item(KIND_FLUSH, 8'd0);
        send_item(KIND_PIXEL, 8'd3);
        send_item(KIND_FLUSH, 8'd0);
        frames += 2;

        // coefficient extremes, flush tick inside the frame, pixel in flush row
        load_kernel(48'h7FFF_8000_7FFF, 48'hFFFF_FFFF_FFFF, 48'h8000_7FFF_8000);
        set_size(4, 3);
        send_item(KIND_PIXEL, 8'd255);
        send_item(KIND_PIXEL, 8'd0);
        send_item(KIND_PIXEL, 8'd255);
        send_item(KIND_PIXEL, 8'd0);
        send_item(KIND_PIXEL, 8'd0);
        send_item(KIND_PIXEL, 8'd255);
        send_item(KIND_FLUSH, 8'd255);
        send_item(KIND_PIXEL, 8'd255);
        send_item(KIND_PIXEL, 8'd255);
        send_item(KIND_PIXEL, 8'd255);
        send_item(KIND_PIXEL, 8'd255);
        send_item(KIND_PIXEL, 8'd0);
        send_item(KIND_FLUSH, 8'd0);
        send_item(KIND_PIXEL, 8'd255);
        send_item(KIND_FLUSH, 8'd170);
        send_item(KIND_FLUSH, 8'd85);
        frames++;

        // random frames, mostly small
        rand_frames = 0;
        while (items_sent < RAND_ITEMS) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            load_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
            set_size(w, h);
            calm = (rand_frames >= 3 && rand_frames < 7);
            run_frame(w, h, ($urandom_range(9) < 3) ? 8 : 0);
            rand_frames++;
        end
        calm = 1'b0;

        // shrink the width in mid-row: column wraps, row stays
        load_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
        set_size(6, 4096);
        repeat (2 * 6 + 3) send_item(KIND_PIXEL, random_pixel());
        quiesce();
        write_reg(REG_IMG_WIDTH, CFG_DATA_W'(2));
        repeat (4) send_item(KIND_PIXEL, random_pixel());
        // row now above the new height: wraps to the first row
        quiesce();
        write_reg(REG_IMG_HEIGHT, CFG_DATA_W'(3));
        run_frame(2, 3, 0);

        // oversized width register acts as the widest row: the row wraps after
        // the widest column, so the first flush ticks already give results
        load_kernel(random_kernel_row(), random_kernel_row(), random_kernel_row());
        set_size(2047, 1);
        hold_req = 1'b1;
        repeat (MAX_WIDTH) send_item(KIND_PIXEL, random_pixel());
        repeat (6) send_item(KIND_FLUSH, 8'd0);

        quiesce();
        $display("Covered %0d frames from %0d items, %0d results checked, %0d mismatches.",
                 frames, items_sent, checked, errors);
        $display("Sizes from 1x1 to full width, mid-frame resize, rounding ties, hold-off.");
        if (errors == 0) begin
            $display("conv3x3_zero_pad_stream_unit test passed");
        end else begin
            $display("conv3x3_zero_pad_stream_unit test failed");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("Timed out with %0d results outstanding.", waiting);
        $display("conv3x3_zero_pad_stream_unit test failed");
        $finish;
    end

endmodule
